FILE: design/sbt_pkg.sv
// Shared types, token codes and character constants for the byte tokenizer.
package sbt_pkg;

  // Token type codes
  localparam logic [4:0] TT_IDENT   = 5'd0;
  localparam logic [4:0] TT_INT     = 5'd1;
  localparam logic [4:0] TT_FLOAT   = 5'd2;
  localparam logic [4:0] TT_STR     = 5'd3;
  localparam logic [4:0] TT_DIV     = 5'd7;

  // Characters the lexer reacts to
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;

  // One result beat
  typedef struct packed {
    logic [4:0]  tok_kind;
    logic [7:0]  text_byte;
    logic        has_byte;
    logic        token_done;
    logic [15:0] line_number;
    logic        unterminated;
    logic        last;
  } sbt_res_t;

  // Results produced by one accepted input beat (zero, one or two)
  typedef struct packed {
    logic [1:0] count;
    sbt_res_t   r0;
    sbt_res_t   r1;
  } sbt_emit_t;

  // Single-character operator table: {hit, token type}
  function automatic logic [5:0] op_lookup(input logic [7:0] c);
    logic [5:0] res;
    begin
      res = 6'd0;
      unique case (c)
        8'h3D:    res = {1'b1, 5'd4};   // =
        8'h2B:    res = {1'b1, 5'd5};   // +
        8'h2D:    res = {1'b1, 5'd6};   // -
        CH_SLASH: res = {1'b1, 5'd7};
        CH_STAR:  res = {1'b1, 5'd8};
        8'h28:    res = {1'b1, 5'd9};   // (
        8'h29:    res = {1'b1, 5'd10};  // )
        8'h7B:    res = {1'b1, 5'd11};  // {
        8'h7D:    res = {1'b1, 5'd12};  // }
        8'h2C:    res = {1'b1, 5'd13};  // ,
        8'h5B:    res = {1'b1, 5'd14};  // [
        8'h5D:    res = {1'b1, 5'd15};  // ]
        8'h3E:    res = {1'b1, 5'd16};  // >
        8'h3C:    res = {1'b1, 5'd17};  // <
        8'h21:    res = {1'b1, 5'd18};  // !
        8'h7E:    res = {1'b1, 5'd19};  // ~
        8'h26:    res = {1'b1, 5'd20};  // &
        8'h7C:    res = {1'b1, 5'd21};  // |
        8'h5E:    res = {1'b1, 5'd22};  // ^
        CH_COLON: res = {1'b1, 5'd23};
        CH_SEMI:  res = {1'b1, 5'd24};
        default:  res = 6'd0;
      endcase
      return res;
    end
  endfunction

endpackage

FILE: design/sbt_lex.sv
// Lexer state machine: holds the lexing state and decodes one byte into results.
module sbt_lex import sbt_pkg::*; #(
  parameter int LINE_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] in_byte,
  input  logic       is_end,
  output sbt_emit_t  emit
);

  typedef enum logic [2:0] {
    M_IDLE, M_IDENT, M_NUM, M_STR, M_SLASH, M_LCOM, M_BCOM, M_BSTAR
  } mode_t;

  localparam int LW = (LINE_BITS > 16) ? LINE_BITS : 16;

  mode_t                mode, mode_next;
  logic                 quote_is_double, quote_is_double_next;
  logic                 number_has_dot, number_has_dot_next;
  logic [LINE_BITS-1:0] line_count, line_count_next;

  logic [LW-1:0] line_wide;
  logic [15:0]   line_clip;

  // Idle decode of the current byte
  logic       idle_emit, idle_qd_wr, idle_qd, idle_dot_clr, idle_nl;
  mode_t      idle_mode;
  sbt_res_t   idle_res;
  logic [5:0] op_hit;

  logic       is_digit, is_alpha, end_in, go_idle, line_inc, dot_v;
  logic [7:0] quote_ch;
  logic [1:0] n;
  sbt_res_t   r0, r1;

  function automatic sbt_res_t mk(input logic [4:0] t, input logic [7:0] b,
                                  input logic hb, input logic dn, input logic ut,
                                  input logic [15:0] ln);
    sbt_res_t r;
    begin
      r.tok_kind     = t;
      r.text_byte    = b;
      r.has_byte     = hb;
      r.token_done   = dn;
      r.line_number  = ln;
      r.unterminated = ut;
      r.last         = 1'b0;
      return r;
    end
  endfunction

  // Line number clipped to 16 bits
  always_comb begin
    line_wide = LW'(line_count);
    line_clip = (line_wide > LW'(16'hFFFF)) ? 16'hFFFF : line_wide[15:0];
  end

  assign is_digit = (in_byte >= 8'h30) && (in_byte <= 8'h39);
  assign is_alpha = ((in_byte >= 8'h61) && (in_byte <= 8'h7A)) ||
                    ((in_byte >= 8'h41) && (in_byte <= 8'h5A));
  assign op_hit   = op_lookup(in_byte);
  assign end_in   = is_end || (in_byte == CH_NUL);
  assign quote_ch = quote_is_double ? CH_DQUOTE : CH_SQUOTE;

  // What the byte does when lexed from idle
  always_comb begin
    idle_emit    = 1'b0;
    idle_qd_wr   = 1'b0;
    idle_qd      = 1'b0;
    idle_dot_clr = 1'b0;
    idle_nl      = 1'b0;
    idle_mode    = M_IDLE;
    idle_res     = mk(TT_IDENT, 8'h00, 1'b0, 1'b0, 1'b0, line_clip);
    priority if (is_digit) begin
      idle_mode    = M_NUM;
      idle_dot_clr = 1'b1;
      idle_emit    = 1'b1;
      idle_res     = mk(TT_INT, in_byte, 1'b1, 1'b0, 1'b0, line_clip);
    end else if (is_alpha) begin
      idle_mode = M_IDENT;
      idle_emit = 1'b1;
      idle_res  = mk(TT_IDENT, in_byte, 1'b1, 1'b0, 1'b0, line_clip);
    end else if ((in_byte == CH_DQUOTE) || (in_byte == CH_SQUOTE)) begin
      idle_mode  = M_STR;
      idle_qd_wr = 1'b1;
      idle_qd    = (in_byte == CH_DQUOTE);
    end else if (in_byte == CH_NL) begin
      idle_nl = 1'b1;
    end else if (in_byte == CH_SLASH) begin
      idle_mode = M_SLASH;
    end else if (op_hit[5]) begin
      idle_emit = 1'b1;
      idle_res  = mk(op_hit[4:0], 8'h00, 1'b0, 1'b1, 1'b0, line_clip);
    end else begin
      // spaces, tabs and any other byte are skipped
      idle_mode = M_IDLE;
    end
  end

  // Per-mode step
  always_comb begin
    mode_next            = mode;
    quote_is_double_next = quote_is_double;
    number_has_dot_next  = number_has_dot;
    line_count_next      = line_count;
    line_inc             = 1'b0;
    go_idle              = 1'b0;
    dot_v                = number_has_dot | (in_byte == CH_DOT);
    n                    = 2'd0;
    r0                   = mk(TT_IDENT, 8'h00, 1'b0, 1'b0, 1'b0, line_clip);
    r1                   = r0;

    if (end_in) begin
      // flush whatever is open, then back to reset state
      unique case (mode)
        M_IDENT: begin
          r0 = mk(TT_IDENT, 8'h00, 1'b0, 1'b1, 1'b0, line_clip);
          n  = 2'd1;
        end
        M_NUM: begin
          r0 = mk(number_has_dot ? TT_FLOAT : TT_INT, 8'h00, 1'b0, 1'b1, 1'b0, line_clip);
          n  = 2'd1;
        end
        M_STR: begin
          r0 = mk(TT_STR, 8'h00, 1'b0, 1'b1, 1'b1, line_clip);
          n  = 2'd1;
        end
        M_SLASH: begin
          r0 = mk(TT_DIV, 8'h00, 1'b0, 1'b1, 1'b0, line_clip);
          n  = 2'd1;
        end
        M_BCOM, M_BSTAR: begin
          r0 = mk(TT_IDENT, 8'h00, 1'b0, 1'b0, 1'b1, line_clip);
          n  = 2'd1;
        end
        M_IDLE, M_LCOM: begin
          n = 2'd0;
        end
      endcase
      mode_next            = M_IDLE;
      quote_is_double_next = 1'b0;
      number_has_dot_next  = 1'b0;
      line_count_next      = LINE_BITS'(1);
    end else begin
      unique case (mode)
        M_IDENT: begin
          if (is_digit || is_alpha) begin
            r0 = mk(TT_IDENT, in_byte, 1'b1, 1'b0, 1'b0, line_clip);
            n  = 2'd1;
          end else begin
            r0      = mk(TT_IDENT, 8'h00, 1'b0, 1'b1, 1'b0, line_clip);
            n       = 2'd1;
            go_idle = 1'b1;
          end
        end
        M_NUM: begin
          if (is_digit || (in_byte == CH_DOT)) begin
            number_has_dot_next = dot_v;
            r0 = mk(dot_v ? TT_FLOAT : TT_INT, in_byte, 1'b1, 1'b0, 1'b0, line_clip);
            n  = 2'd1;
          end else begin
            r0 = mk(number_has_dot ? TT_FLOAT : TT_INT, 8'h00, 1'b0, 1'b1, 1'b0, line_clip);
            n  = 2'd1;
            number_has_dot_next = 1'b0;
            go_idle = 1'b1;
          end
        end
        M_STR: begin
          if (in_byte == quote_ch) begin
            r0        = mk(TT_STR, 8'h00, 1'b0, 1'b1, 1'b0, line_clip);
            mode_next = M_IDLE;
          end else begin
            r0 = mk(TT_STR, in_byte, 1'b1, 1'b0, 1'b0, line_clip);
          end
          n = 2'd1;
        end
        M_SLASH: begin
          priority if (in_byte == CH_SLASH) begin
            mode_next = M_LCOM;
          end else if (in_byte == CH_STAR) begin
            mode_next = M_BCOM;
          end else begin
            r0      = mk(TT_DIV, 8'h00, 1'b0, 1'b1, 1'b0, line_clip);
            n       = 2'd1;
            go_idle = 1'b1;
          end
        end
        M_LCOM: begin
          if (in_byte == CH_NL) begin
            line_inc  = 1'b1;
            mode_next = M_IDLE;
          end
        end
        M_BCOM: begin
          if (in_byte == CH_STAR) begin
            mode_next = M_BSTAR;
          end
        end
        M_BSTAR: begin
          priority if (in_byte == CH_SLASH) begin
            mode_next = M_IDLE;
          end else if (in_byte != CH_STAR) begin
            mode_next = M_BCOM;
          end else begin
            mode_next = M_BSTAR;  // a further star keeps the close pending
          end
        end
        M_IDLE: begin
          go_idle = 1'b1;
        end
      endcase

      // relex the byte from idle after a close (or in idle itself)
      if (go_idle) begin
        mode_next = idle_mode;
        if (idle_qd_wr) begin
          quote_is_double_next = idle_qd;
        end
        if (idle_dot_clr) begin
          number_has_dot_next = 1'b0;
        end
        if (idle_nl) begin
          line_inc = 1'b1;
        end
        if (idle_emit) begin
          if (n == 2'd0) begin
            r0 = idle_res;
            n  = 2'd1;
          end else begin
            r1 = idle_res;
            n  = 2'd2;
          end
        end
      end

      // saturating line counter
      if (line_inc && (line_count != {LINE_BITS{1'b1}})) begin
        line_count_next = line_count + LINE_BITS'(1);
      end
    end

    // mark the final beat of this input
    if (n == 2'd1) begin
      r0.last = 1'b1;
    end
    if (n == 2'd2) begin
      r1.last = 1'b1;
    end
  end

  assign emit.count = n;
  assign emit.r0    = r0;
  assign emit.r1    = r1;

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= M_IDLE;
      quote_is_double <= 1'b0;
      number_has_dot  <= 1'b0;
      line_count      <= LINE_BITS'(1);
    end else if (accept) begin
      mode            <= mode_next;
      quote_is_double <= quote_is_double_next;
      number_has_dot  <= number_has_dot_next;
      line_count      <= line_count_next;
    end
  end

endmodule

FILE: design/source_byte_tokenizer.sv
// Top level of the byte tokenizer: lexer plus result queue.
//
// Takes one source byte per beat and returns token text and token close
// beats. Throughput is one byte per cycle while in_stall is low: a byte
// is decoded in the cycle it is accepted and its results are written into
// a four-entry result queue, whose head drives the output beat. Most
// bytes give zero or one result; a byte that closes a token and also starts
// a new one gives two. The queue takes up to two results a cycle but hands
// out one, so each such byte leaves one more result waiting. in_stall is
// high while three or more results are queued; with a free output that
// needs a second two-result byte before the first has drained. A zero byte
// or is_end flushes any open token and restarts at line 1.
module source_byte_tokenizer import sbt_pkg::*; #(
  parameter int LINE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        is_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  tok_kind,
  output logic [7:0]  text_byte,
  output logic        has_byte,
  output logic        token_done,
  output logic [15:0] line_number,
  output logic        unterminated,
  output logic        last
);

  sbt_emit_t  emit;
  sbt_res_t   q [4];
  sbt_res_t   head;
  logic [1:0] wr, rd;
  logic [2:0] count, count_next;
  logic [2:0] push;
  logic       accept, pop;

  assign in_stall  = (count > 3'd2);
  assign accept    = in_valid && !in_stall;
  assign out_valid = (count != 3'd0);
  assign pop       = out_valid && !out_stall;
  assign push      = accept ? {1'b0, emit.count} : 3'd0;

  sbt_lex #(
    .LINE_BITS(LINE_BITS)
  ) u_lex (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_byte (in_byte),
    .is_end  (is_end),
    .emit    (emit)
  );

  // Queue bookkeeping
  always_comb begin
    count_next = count + push - {2'b00, pop};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr    <= 2'd0;
      rd    <= 2'd0;
      count <= 3'd0;
    end else begin
      wr    <= wr + push[1:0];
      rd    <= rd + {1'b0, pop};
      count <= count_next;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (accept && (emit.count != 2'd0)) begin
      q[wr] <= emit.r0;
    end
    if (accept && (emit.count == 2'd2)) begin
      q[wr + 2'd1] <= emit.r1;
    end
  end

  // Head of queue drives the output beat
  assign head         = q[rd];
  assign tok_kind     = head.tok_kind;
  assign text_byte    = head.text_byte;
  assign has_byte     = head.has_byte;
  assign token_done   = head.token_done;
  assign line_number  = head.line_number;
  assign unterminated = head.unterminated;
  assign last         = head.last;

endmodule

FILE: design/sbt_checker.sv
// Port-level checks for the byte tokenizer, bound to the top level.
module sbt_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [4:0]  tok_kind,
  input logic [7:0]  text_byte,
  input logic        has_byte,
  input logic        token_done,
  input logic [15:0] line_number,
  input logic        unterminated,
  input logic        last
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(tok_kind) &&
      $stable(text_byte) && $stable(has_byte) && $stable(token_done) &&
      $stable(line_number) && $stable(unterminated) && $stable(last))
    else $error("stalled result beat changed");

  // Nothing queued straight after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // An empty queue never stalls the input
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with no result pending");

  // The second result of a pair is already queued behind the first
  a_pair_follow: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last |=> out_valid)
    else $error("second result of a pair missing");

endmodule

bind source_byte_tokenizer sbt_checker u_sbt_checker (.*);
